@@ rtl/vwcr_pkg.sv @@
package vwcr_pkg;

  // Field widths of the channels.
  localparam int unsigned VER_W  = 15;
  localparam int unsigned HALF_W = 64;
  localparam int unsigned WORD_W = 2 * HALF_W;
  localparam int unsigned SIZE_W = 5;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned STAT_W = 3;

  // Defaults for the top-level parameters.
  localparam int unsigned STACK_DEPTH_DEF   = 32;
  localparam int unsigned VERSION_LIMIT_DEF = 30000;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_SAVE    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RESTORE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SYNC    = 3'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_LIMIT   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_RESTORE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_SIZE    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;

  // Supported word sizes in bytes.
  localparam logic [SIZE_W-1:0] SIZE_4B  = 5'd4;
  localparam logic [SIZE_W-1:0] SIZE_8B  = 5'd8;
  localparam logic [SIZE_W-1:0] SIZE_16B = 5'd16;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [VER_W-1:0]  target_version;
    logic [HALF_W-1:0] data_low;
    logic [HALF_W-1:0] data_high;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VER_W-1:0]  version_out;
    logic [HALF_W-1:0] read_low;
    logic [HALF_W-1:0] read_high;
  } rsp_t;

  typedef logic [SIZE_W-1:0] cfg_t;

  // One snapshot entry held by a stack cell.
  typedef struct packed {
    logic [WORD_W-1:0] content;
    logic [VER_W-1:0]  version;
  } snap_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP
  } stack_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SYNC,
    S_RESULT
  } state_t;

  function automatic logic size_ok(input logic [SIZE_W-1:0] bytes);
    return (bytes == SIZE_4B) || (bytes == SIZE_8B) || (bytes == SIZE_16B);
  endfunction

  // Byte mask of the word, high half in the upper bits.
  function automatic logic [WORD_W-1:0] size_mask(input logic [SIZE_W-1:0] bytes);
    logic [WORD_W-1:0] m;
    case (bytes)
      SIZE_4B:  m = {{HALF_W{1'b0}}, {(HALF_W/2){1'b0}}, {(HALF_W/2){1'b1}}};
      SIZE_8B:  m = {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
      SIZE_16B: m = {WORD_W{1'b1}};
      default:  m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/vwcr_stream_if.sv @@
interface vwcr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/vwcr_cell.sv @@
module vwcr_cell (
  input  logic                clk,
  input  vwcr_pkg::stack_op_t op,
  input  vwcr_pkg::snap_t     from_above,
  input  vwcr_pkg::snap_t     from_below,
  output vwcr_pkg::snap_t     q
);

  // A push moves every entry one place down, a pop one place up.
  always_ff @(posedge clk) begin
    case (op)
      vwcr_pkg::OP_PUSH: q <= from_above;
      vwcr_pkg::OP_POP:  q <= from_below;
      default:           q <= q;
    endcase
  end

endmodule

@@ rtl/versioned_word_checkpoint_rollback.sv @@
// Versioned word with a snapshot stack. The block keeps one live word of 4, 8
// or 16 bytes (block_bytes, to be written by the user on the cfg channel only
// while idle, which the block does not enforce), a version counter and a stack
// of STACK_DEPTH snapshots held in a row of cells, top at cell 0, that shift as
// a whole on each push or pop. One request is in flight at a time. Save,
// restore and write update the state on acceptance; the result state then
// loads the output register once any earlier result has been taken. A sync
// that reaches the stack passes the sync state, where the cell row pops one
// entry per cycle above the target, and restores the word from the top
// entry, or from the last entry popped when it empties the stack. The output
// register lets the next request in while a result still waits to be taken.
module versioned_word_checkpoint_rollback #(
  parameter int unsigned STACK_DEPTH   = vwcr_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VERSION_LIMIT = vwcr_pkg::VERSION_LIMIT_DEF
) (
  input logic         clk,
  input logic         rst,
  vwcr_stream_if.sink   req,
  vwcr_stream_if.source rsp,
  vwcr_stream_if.sink   cfg
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VER_W = vwcr_pkg::VER_W;
  localparam int unsigned WORD_W = vwcr_pkg::WORD_W;

  vwcr_pkg::state_t          state, state_next;
  logic [VER_W-1:0]          cur_ver, cur_ver_next;
  logic [WORD_W-1:0]         live, live_next;
  logic [CNT_W-1:0]          count, count_next;
  logic [VER_W-1:0]          sync_target, sync_target_next;
  logic [vwcr_pkg::STAT_W-1:0] req_status, req_status_next;
  logic [VER_W-1:0]          req_version, req_version_next;
  logic                      rsp_valid, rsp_valid_next;
  vwcr_pkg::rsp_t            rsp_q, rsp_q_next;
  logic [vwcr_pkg::SIZE_W-1:0] block_bytes;

  vwcr_pkg::stack_op_t       op;
  vwcr_pkg::snap_t           push_entry;
  vwcr_pkg::snap_t           cell_q [STACK_DEPTH];
  vwcr_pkg::snap_t           top;
  vwcr_pkg::req_t            r;
  logic [WORD_W-1:0]         mask;
  logic                      push;

  assign top  = cell_q[0];
  assign r    = req.data;
  assign mask = vwcr_pkg::size_mask(block_bytes);

  assign req.ready = (state == vwcr_pkg::S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_q;

  // Snapshot stack: a row of cells, each handing its entry to a neighbor.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    vwcr_pkg::snap_t above, below;
    if (i == 0) begin : g_first
      assign above = push_entry;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = cell_q[i];
    end else begin : g_inner
      assign below = cell_q[i+1];
    end
    vwcr_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[i])
    );
  end

  // Request sequencing and next state.
  always_comb begin
    state_next       = state;
    cur_ver_next     = cur_ver;
    live_next        = live;
    count_next       = count;
    sync_target_next = sync_target;
    req_status_next  = req_status;
    req_version_next = req_version;
    rsp_valid_next   = rsp_valid & ~rsp.ready;
    rsp_q_next       = rsp_q;
    op               = vwcr_pkg::OP_HOLD;
    push_entry.content = live & mask;
    push_entry.version = r.target_version - VER_W'(1);
    push             = 1'b0;

    case (state)
      vwcr_pkg::S_IDLE: begin
        if (req.valid) begin
          req_status_next = vwcr_pkg::STAT_OK;
          state_next      = vwcr_pkg::S_RESULT;
          case (r.req_type)
            vwcr_pkg::REQ_SAVE: begin
              if (cur_ver >= VER_W'(VERSION_LIMIT)) begin
                req_status_next = vwcr_pkg::STAT_LIMIT;
              end else begin
                cur_ver_next = cur_ver + VER_W'(1);
              end
            end
            vwcr_pkg::REQ_RESTORE: begin
              if (r.target_version > cur_ver) begin
                req_status_next = vwcr_pkg::STAT_RESTORE;
              end else begin
                cur_ver_next = r.target_version;
              end
            end
            vwcr_pkg::REQ_WRITE: begin
              if (!vwcr_pkg::size_ok(block_bytes)) begin
                req_status_next = vwcr_pkg::STAT_SIZE;
              end else begin
                // Skip the snapshot for target version 0 or when the top already holds the prior version.
                push = (r.target_version != '0) &&
                       !((count != '0) && (top.version == push_entry.version));
                if (push && (count == CNT_W'(STACK_DEPTH))) begin
                  req_status_next = vwcr_pkg::STAT_FULL;
                end else begin
                  if (push) begin
                    op         = vwcr_pkg::OP_PUSH;
                    count_next = count + CNT_W'(1);
                  end
                  live_next = (live & ~mask) | ({r.data_high, r.data_low} & mask);
                end
              end
            end
            vwcr_pkg::REQ_SYNC: begin
              if (!vwcr_pkg::size_ok(block_bytes)) begin
                req_status_next = vwcr_pkg::STAT_SIZE;
              end else if ((count != '0) && (top.version >= r.target_version)) begin
                sync_target_next = r.target_version;
                state_next       = vwcr_pkg::S_SYNC;
              end
            end
            default: begin
            end
          endcase
          // Save reports the version before the bump, all else the new one.
          req_version_next = (r.req_type == vwcr_pkg::REQ_SAVE) ? cur_ver : cur_ver_next;
        end
      end

      vwcr_pkg::S_SYNC: begin
        if (top.version > sync_target) begin
          // Pop one newer entry; the last one popped restores the word.
          op         = vwcr_pkg::OP_POP;
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            live_next  = (live & ~mask) | (top.content & mask);
            state_next = vwcr_pkg::S_RESULT;
          end
        end else begin
          live_next  = (live & ~mask) | (top.content & mask);
          state_next = vwcr_pkg::S_RESULT;
          if (top.version == sync_target) begin
            op         = vwcr_pkg::OP_POP;
            count_next = count - CNT_W'(1);
          end
        end
      end

      vwcr_pkg::S_RESULT: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next         = 1'b1;
          rsp_q_next.status      = req_status;
          rsp_q_next.version_out = req_version;
          rsp_q_next.read_low    = live[vwcr_pkg::HALF_W-1:0] & mask[vwcr_pkg::HALF_W-1:0];
          rsp_q_next.read_high   = live[WORD_W-1:vwcr_pkg::HALF_W] &
                                   mask[WORD_W-1:vwcr_pkg::HALF_W];
          state_next             = vwcr_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = vwcr_pkg::S_IDLE;
      end
    endcase
  end

  // Control state and architectural registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= vwcr_pkg::S_IDLE;
      cur_ver     <= '0;
      live        <= '0;
      count       <= '0;
      rsp_valid   <= 1'b0;
      block_bytes <= vwcr_pkg::SIZE_8B;
    end else begin
      state     <= state_next;
      cur_ver   <= cur_ver_next;
      live      <= live_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
      if (cfg.valid) begin
        block_bytes <= cfg.data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sync_target <= sync_target_next;
    req_status  <= req_status_next;
    req_version <= req_version_next;
    rsp_q       <= rsp_q_next;
  end

endmodule

@@ rtl/vwcr_checker.sv @@
module vwcr_checker #(
  parameter int unsigned VERSION_LIMIT = vwcr_pkg::VERSION_LIMIT_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input vwcr_pkg::rsp_t rsp_data
);

  // One request at a time: the block is busy right after it takes one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one in progress");

  // A stalled result stays on the port unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");

  // An unsupported size shows no word bytes.
  a_size_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == vwcr_pkg::STAT_SIZE) |->
      (rsp_data.read_low == '0) && (rsp_data.read_high == '0))
    else $error("word bytes shown with unsupported size");

  // A refused save reports a version at the limit.
  a_limit_version: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == vwcr_pkg::STAT_LIMIT) |->
      rsp_data.version_out >= vwcr_pkg::VER_W'(VERSION_LIMIT))
    else $error("version limit reported below the limit");

endmodule

bind versioned_word_checkpoint_rollback vwcr_checker #(
  .VERSION_LIMIT (VERSION_LIMIT)
) u_vwcr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
